// ----- rtl/loopback_latency_meter_macros.svh -----
// Assertion macros for the loopback latency meter.
// Checks compile in simulation only; synthesis sees empty bodies.
`ifndef LOOPBACK_LATENCY_METER_MACROS_SVH
`define LOOPBACK_LATENCY_METER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define LBLM_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lblm assertion failed");

// Next-cycle implication.
`define LBLM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lblm assertion failed");

// Invariant.
`define LBLM_ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("lblm assertion failed");

`else

`define LBLM_ASSERT_IMPL(name, clk, rst, ante, cons)
`define LBLM_ASSERT_NEXT(name, clk, rst, ante, cons)
`define LBLM_ASSERT_ALWAYS(name, clk, rst, cond)

`endif

`endif

// ----- rtl/lblm_pkg.sv -----
// Shared types and constants of the loopback latency meter.
// No dependencies; the meter, lblm_stats and the sim files import it.
`default_nettype none

package lblm_pkg;

   localparam int LBLM_MAX_MEASUREMENTS = 64;
   localparam int LBLM_IMPULSE_LENGTH   = 5;
   localparam int NUM_WORDS             = 5;

   localparam int SAMPLE_W  = 16;
   localparam int SILENCE_W = 20;
   localparam int THRESH_W  = 15;
   localparam int LIMIT_W   = 7;
   localparam int FRAME_W   = 24;
   localparam int MAG_W     = 48;
   localparam int COUNT_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [SILENCE_W-1:0] SILENCE_RESET = 20'd10000;
   localparam logic [THRESH_W-1:0]  THRESH_RESET  = 15'd3277;
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 7'd64;
   localparam logic signed [SAMPLE_W-1:0] WORD_RESET [NUM_WORDS] =
      '{16'sd16384, 16'sd29491, 16'sd0, -16'sd29491, -16'sd16384};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SILENCE_LENGTH    = 3'd0,
      CSR_PEAK_THRESHOLD    = 3'd1,
      CSR_MEASUREMENT_LIMIT = 3'd2,
      CSR_IMPULSE_WORD_0    = 3'd3,
      CSR_IMPULSE_WORD_1    = 3'd4,
      CSR_IMPULSE_WORD_2    = 3'd5,
      CSR_IMPULSE_WORD_3    = 3'd6,
      CSR_IMPULSE_WORD_4    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_SILENT = 2'd0,
      PH_LISTEN = 2'd1,
      PH_DONE   = 2'd2
   } phase_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] in_sample;
   } lblm_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_sample;
      logic                       latency_valid;
      logic [FRAME_W-1:0]         latency_frames;
      logic [LIMIT_W-1:0]         measurements_taken;
      logic                       finished;
      logic [THRESH_W-1:0]        peak_level;
      logic [MAG_W-1:0]           magnitude_sum;
      logic [COUNT_W-1:0]         samples_seen;
   } lblm_rsp_type;

   typedef struct packed {
      logic [THRESH_W-1:0] peak;
      logic [MAG_W-1:0]    mag_sum;
      logic [COUNT_W-1:0]  count;
   } lblm_stats_type;

endpackage

`default_nettype wire

// ----- rtl/lblm_stream_if.sv -----
// Valid/ready stream channel carrying one payload per transfer.
// Payload type is set per instance; used with lblm_pkg structs.
`default_nettype none

interface lblm_stream_if #(
   parameter type payload_type = logic [0:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/loopback_latency_meter.sv -----
// Loopback latency meter top level: control state machine, config registers, output register.
// Depends on lblm_pkg, lblm_stream_if, lblm_stats and the assertion macro header.
`default_nettype none
`include "loopback_latency_meter_macros.svh"

// One recorded sample enters per transfer on req_ch and one playback result
// leaves per transfer on rsp_ch. The block takes a sample in every clock cycle while
// its output is not stalled: each sample is handled in a single pass of logic and its
// result lands in one output register the cycle after the transfer, so throughput is
// one sample per clock while the sink keeps taking results. req_ch.ready drops only while
// that register holds a result that the sink is not taking. After reset the block
// counts silence_length + 1 samples, plays the impulse words one per sample,
// and reports the sample count from impulse start to the first input at or above
// peak_threshold; after measurement_limit measurements it stops measuring while
// the statistics keep running. Configuration writes on csr_* apply to the next
// sample and are meant for idle periods.
module loopback_latency_meter #(
   parameter int MAX_MEASUREMENTS = lblm_pkg::LBLM_MAX_MEASUREMENTS,
   parameter int IMPULSE_LENGTH   = lblm_pkg::LBLM_IMPULSE_LENGTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   lblm_stream_if.sink                                req_ch,
   lblm_stream_if.source                              rsp_ch,
   input  wire logic                                  csr_we,
   input  wire logic [lblm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [lblm_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import lblm_pkg::*;

   localparam int POS_W  = $clog2(IMPULSE_LENGTH + 1);
   localparam int MEAS_W = $clog2(MAX_MEASUREMENTS + 1);
   localparam int LIM_W  = (MEAS_W > LIMIT_W) ? MEAS_W : LIMIT_W;

   // configuration
   logic [SILENCE_W-1:0]       silence_ff;
   logic [THRESH_W-1:0]        thresh_ff;
   logic [LIMIT_W-1:0]         limit_ff;
   logic signed [SAMPLE_W-1:0] word_ff [NUM_WORDS];

   // measurement state
   phase_type          phase_ff, phase_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [MEAS_W-1:0]  meas_ff, meas_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   lblm_rsp_type rsp_data_ff, rsp_data_in;

   logic                       accept;
   logic signed [SAMPLE_W-1:0] sample;
   lblm_stats_type             stats_next;

   logic                       start;
   logic                       hit;
   logic                       playing;
   phase_type                  phase_mid;
   logic [FRAME_W-1:0]         frame_plus;
   logic [FRAME_W-1:0]         frame_mid;
   logic [POS_W-1:0]           pos_start;
   logic signed [SAMPLE_W-1:0] word_sel;
   logic [LIM_W-1:0]           lim_nz;
   logic [LIM_W-1:0]           lim_eff;
   logic [LIM_W-1:0]           meas_inc;

   assign sample       = req_ch.payload.in_sample;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   lblm_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .sample_en  (accept),
      .sample     (sample),
      .stats_next (stats_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         silence_ff <= SILENCE_RESET;
         thresh_ff  <= THRESH_RESET;
         limit_ff   <= LIMIT_RESET;
         for (int i = 0; i < NUM_WORDS; i++) begin
            word_ff[i] <= WORD_RESET[i];
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_SILENCE_LENGTH:    silence_ff <= csr_wdata[SILENCE_W-1:0];
            CSR_PEAK_THRESHOLD:    thresh_ff  <= csr_wdata[THRESH_W-1:0];
            CSR_MEASUREMENT_LIMIT: limit_ff   <= csr_wdata[LIMIT_W-1:0];
            CSR_IMPULSE_WORD_0:    word_ff[0] <= csr_wdata[SAMPLE_W-1:0];
            CSR_IMPULSE_WORD_1:    word_ff[1] <= csr_wdata[SAMPLE_W-1:0];
            CSR_IMPULSE_WORD_2:    word_ff[2] <= csr_wdata[SAMPLE_W-1:0];
            CSR_IMPULSE_WORD_3:    word_ff[3] <= csr_wdata[SAMPLE_W-1:0];
            CSR_IMPULSE_WORD_4:    word_ff[4] <= csr_wdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SILENT;
         frame_ff <= '0;
         pos_ff   <= POS_W'(IMPULSE_LENGTH);
         meas_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         frame_ff <= frame_in;
         pos_ff   <= pos_in;
         meas_ff  <= meas_in;
      end
   end

   // next state and result for the sample on the input side
   always_comb begin
      phase_in  = phase_ff;
      meas_in   = meas_ff;
      hit       = 1'b0;
      word_sel  = '0;

      // silence count; never wraps since it stays within silence_length + 1
      frame_plus = frame_ff + 1'b1;
      start      = (phase_ff == PH_SILENT) && (frame_plus > FRAME_W'(silence_ff));
      phase_mid  = start ? PH_LISTEN : phase_ff;
      if (phase_ff == PH_SILENT) begin
         frame_mid = start ? '0 : frame_plus;
      end else begin
         frame_mid = frame_ff;
      end

      // impulse playback, restarted on every new start
      pos_start = start ? '0 : pos_ff;
      playing   = pos_start < POS_W'(IMPULSE_LENGTH);
      for (int i = 0; i < NUM_WORDS; i++) begin
         if (32'(pos_start) == i) begin
            word_sel = word_ff[i];
         end
      end
      pos_in = playing ? pos_start + 1'b1 : pos_start;

      // clamp the limit to one and to capacity
      lim_nz   = (limit_ff == '0) ? LIM_W'(1) : LIM_W'(limit_ff);
      lim_eff  = (lim_nz > LIM_W'(MAX_MEASUREMENTS)) ? LIM_W'(MAX_MEASUREMENTS) : lim_nz;
      meas_inc = LIM_W'(meas_ff) + 1'b1;

      frame_in = frame_mid;
      if (phase_mid == PH_LISTEN) begin
         if ($signed({sample[SAMPLE_W-1], sample}) >= $signed({2'b00, thresh_ff})) begin
            hit      = 1'b1;
            meas_in  = MEAS_W'(meas_inc);
            phase_in = (meas_inc >= lim_eff) ? PH_DONE : PH_SILENT;
            frame_in = '0;
         end else begin
            phase_in = PH_LISTEN;
            if (frame_mid != {FRAME_W{1'b1}}) begin
               frame_in = frame_mid + 1'b1;
            end
         end
      end

      rsp_data_in.out_sample         = playing ? word_sel : '0;
      rsp_data_in.latency_valid      = hit;
      rsp_data_in.latency_frames     = hit ? frame_mid : '0;
      rsp_data_in.measurements_taken = LIMIT_W'(meas_in);
      rsp_data_in.finished           = (phase_in == PH_DONE);
      rsp_data_in.peak_level         = stats_next.peak;
      rsp_data_in.magnitude_sum      = stats_next.mag_sum;
      rsp_data_in.samples_seen       = stats_next.count;
   end

   // hold an untaken result, load on each input transfer
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   `LBLM_ASSERT_NEXT(a_done_sticky, clock, reset, phase_ff == PH_DONE, phase_ff == PH_DONE)
   `LBLM_ASSERT_NEXT(a_meas_step, clock, reset, accept && hit, meas_ff == MEAS_W'($past(meas_ff) + 1'b1))
   `LBLM_ASSERT_IMPL(a_flag_count, clock, reset, rsp_valid_ff && rsp_data_ff.latency_valid, meas_ff != '0)
   `LBLM_ASSERT_ALWAYS(a_pos_range, clock, reset, pos_ff <= POS_W'(IMPULSE_LENGTH))

endmodule

`default_nettype wire

// ----- rtl/lblm_stats.sv -----
// Input statistics: peak sample, saturating magnitude sum, saturating count.
// Depends on lblm_pkg.
`default_nettype none

module lblm_stats (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 sample_en,
   input  wire logic signed [lblm_pkg::SAMPLE_W-1:0] sample,
   output lblm_pkg::lblm_stats_type                  stats_next
);
   import lblm_pkg::*;

   logic [THRESH_W-1:0] peak_ff, peak_in;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic signed [SAMPLE_W:0] s_ext;
   logic signed [SAMPLE_W:0] peak_ext;
   logic [SAMPLE_W-1:0]      mag;
   logic [MAG_W:0]           sum;

   always_comb begin
      s_ext    = {sample[SAMPLE_W-1], sample};
      peak_ext = {2'b00, peak_ff};
      peak_in  = (s_ext > peak_ext) ? sample[THRESH_W-1:0] : peak_ff;
      mag      = sample[SAMPLE_W-1] ? SAMPLE_W'(-s_ext) : SAMPLE_W'(s_ext);
      sum      = {1'b0, mag_ff} + (MAG_W+1)'(mag);
      // saturate on carry out
      mag_in   = sum[MAG_W] ? {MAG_W{1'b1}} : sum[MAG_W-1:0];
      count_in = (&count_ff) ? count_ff : count_ff + 1'b1;

      stats_next.peak    = peak_in;
      stats_next.mag_sum = mag_in;
      stats_next.count   = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff  <= '0;
         mag_ff   <= '0;
         count_ff <= '0;
      end else if (sample_en) begin
         peak_ff  <= peak_in;
         mag_ff   <= mag_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- sim/latency_meter_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the loopback latency meter: predicts each result from the accepted samples.
// Depends on lblm_pkg; watches the req/rsp channels and the csr write port of the block.

module latency_meter_checker import lblm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  lblm_req_type          req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  lblm_rsp_type          rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    outstanding,
   output int                    fail_count
);

   localparam logic [MAG_W-1:0]   MAG_FULL   = {MAG_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_FULL = {COUNT_W{1'b1}};
   localparam int unsigned        FRAME_FULL = (1 << FRAME_W) - 1;

   // configuration copy
   logic [SILENCE_W-1:0]       silence_cfg;
   logic [THRESH_W-1:0]        thresh_cfg;
   logic [LIMIT_W-1:0]         limit_cfg;
   logic signed [SAMPLE_W-1:0] word_cfg [NUM_WORDS];

   // meter state
   phase_type          phase_q;
   int unsigned        frames_q;
   int unsigned        play_pos;
   int unsigned        meas_q;
   logic [THRESH_W-1:0] peak_q;
   logic [MAG_W-1:0]    mag_q;
   logic [COUNT_W-1:0]  seen_q;

   lblm_rsp_type expected_readings [$];
   int           mismatches;

   function automatic lblm_rsp_type advance_meter(input logic signed [SAMPLE_W-1:0] sample);
      lblm_rsp_type r;
      int           s;
      int           mag;
      int unsigned  eff_limit;
      r = '0;
      s = sample;
      if (s > int'(peak_q)) peak_q = sample[THRESH_W-1:0];
      mag = (s < 0) ? -s : s;
      if (mag_q > MAG_FULL - MAG_W'(mag)) mag_q = MAG_FULL;
      else mag_q = mag_q + MAG_W'(mag);
      if (seen_q != COUNT_FULL) seen_q = seen_q + 1'b1;

      if (phase_q == PH_SILENT) begin
         frames_q = frames_q + 1;
         if (frames_q > silence_cfg) begin
            play_pos = 0;
            phase_q  = PH_LISTEN;
            frames_q = 0;
         end
      end

      // the impulse plays to its end unless a new start restarts it
      if (play_pos < LBLM_IMPULSE_LENGTH) begin
         r.out_sample = (play_pos < NUM_WORDS) ? word_cfg[play_pos] : '0;
         play_pos = play_pos + 1;
      end

      if (phase_q == PH_LISTEN) begin
         if (s >= int'(thresh_cfg)) begin
            r.latency_valid  = 1'b1;
            r.latency_frames = frames_q[FRAME_W-1:0];
            meas_q = meas_q + 1;
            eff_limit = (limit_cfg == 0) ? 1 : limit_cfg;
            if (eff_limit > LBLM_MAX_MEASUREMENTS) eff_limit = LBLM_MAX_MEASUREMENTS;
            phase_q  = (meas_q >= eff_limit) ? PH_DONE : PH_SILENT;
            frames_q = 0;
         end else if (frames_q < FRAME_FULL) begin
            frames_q = frames_q + 1;
         end
      end

      r.measurements_taken = meas_q[LIMIT_W-1:0];
      r.finished           = (phase_q == PH_DONE);
      r.peak_level         = peak_q;
      r.magnitude_sum      = mag_q;
      r.samples_seen       = seen_q;
      return r;
   endfunction

   function automatic string describe(input lblm_rsp_type r);
      return $sformatf("out=%0d lat_v=%0d lat=%0d meas=%0d fin=%0d peak=%0d mag=%0d cnt=%0d",
                       r.out_sample, r.latency_valid, r.latency_frames,
                       r.measurements_taken, r.finished, r.peak_level,
                       r.magnitude_sum, r.samples_seen);
   endfunction

   always @(posedge clock) begin : watch
      lblm_rsp_type want;
      logic         bad;
      if (reset) begin
         silence_cfg = SILENCE_RESET;
         thresh_cfg  = THRESH_RESET;
         limit_cfg   = LIMIT_RESET;
         for (int i = 0; i < NUM_WORDS; i++) word_cfg[i] = WORD_RESET[i];
         phase_q  = PH_SILENT;
         frames_q = 0;
         play_pos = LBLM_IMPULSE_LENGTH;
         meas_q   = 0;
         peak_q   = '0;
         mag_q    = '0;
         seen_q   = '0;
         mismatches = 0;
         expected_readings.delete();
      end else begin
         if (req_valid && req_ready)
            expected_readings.push_back(advance_meter(req_payload.in_sample));

         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] result with nothing pending: %s", $realtime,
                           describe(rsp_payload));
            end else begin
               want = expected_readings.pop_front();
               bad = 1'b0;
               if (rsp_payload.out_sample !== want.out_sample) bad = 1'b1;
               if (rsp_payload.latency_valid !== want.latency_valid) bad = 1'b1;
               if (rsp_payload.latency_frames !== want.latency_frames) bad = 1'b1;
               if (rsp_payload.measurements_taken !== want.measurements_taken) bad = 1'b1;
               if (rsp_payload.finished !== want.finished) bad = 1'b1;
               if (rsp_payload.peak_level !== want.peak_level) bad = 1'b1;
               if (rsp_payload.magnitude_sum !== want.magnitude_sum) bad = 1'b1;
               if (rsp_payload.samples_seen !== want.samples_seen) bad = 1'b1;
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("[%0t] mismatch", $realtime);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(rsp_payload));
                  end
               end
            end
         end

         // register writes apply from the next sample on
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SILENCE_LENGTH:    silence_cfg = csr_wdata[SILENCE_W-1:0];
               CSR_PEAK_THRESHOLD:    thresh_cfg  = csr_wdata[THRESH_W-1:0];
               CSR_MEASUREMENT_LIMIT: limit_cfg   = csr_wdata[LIMIT_W-1:0];
               CSR_IMPULSE_WORD_0:    word_cfg[0] = csr_wdata[SAMPLE_W-1:0];
               CSR_IMPULSE_WORD_1:    word_cfg[1] = csr_wdata[SAMPLE_W-1:0];
               CSR_IMPULSE_WORD_2:    word_cfg[2] = csr_wdata[SAMPLE_W-1:0];
               CSR_IMPULSE_WORD_3:    word_cfg[3] = csr_wdata[SAMPLE_W-1:0];
               CSR_IMPULSE_WORD_4:    word_cfg[4] = csr_wdata[SAMPLE_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding <= expected_readings.size();
      fail_count  <= mismatches;
   end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Top of the loopback latency meter testbench: clock, reset, stimulus, verdict.
// Depends on lblm_pkg, lblm_stream_if, the block itself and latency_meter_checker.

module tb;
   import lblm_pkg::*;

   localparam int RANDOM_ITEMS = 450;
   localparam int MEAS_CAP     = 50;
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 200;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    outstanding;
   int                    fail_count;

   lblm_stream_if #(.payload_type(lblm_req_type)) req_ch ();
   lblm_stream_if #(.payload_type(lblm_rsp_type)) rsp_ch ();

   loopback_latency_meter dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   latency_meter_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_payload (req_ch.payload),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_ch.payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stimulus shaping state
   int          cur_silence;
   int          cur_thr;
   int          items_sent;
   int unsigned meas_seen;
   int          results_taken;
   logic        tx_burst;
   logic        rx_burst;
   int          idle_cycles;

   task automatic send_sample(input int v);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.payload.in_sample <= v[SAMPLE_W-1:0];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // drop valid and wait until every result is back and the block is quiet
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic program_meter(input int silence, input int thr, input int limit,
                                input int word_style);
      logic [CSR_DATA_W-1:0] data;
      int                    word;
      settle();
      for (int i = 0; i < 8; i++) begin
         case (word_style)
            1:       word = (i % 2 == 0) ? 32767 : -32768;
            2:       word = (i % 2 == 0) ? -32768 : 32767;
            3:       word = (i == 3) ? 32767 : (i == 4) ? -32768 : (i == 5) ? 1 :
                            (i == 6) ? -1 : 0;
            default: word = int'($urandom_range(0, 65535)) - 32768;
         endcase
         case (csr_index_type'(i))
            CSR_SILENCE_LENGTH:    data = silence[SILENCE_W-1:0];
            CSR_PEAK_THRESHOLD:    data = {5'($urandom), thr[THRESH_W-1:0]};
            CSR_MEASUREMENT_LIMIT: data = {13'($urandom), limit[LIMIT_W-1:0]};
            default:               data = {4'($urandom), word[SAMPLE_W-1:0]};
         endcase
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= data;
         @(posedge clock);
      end
      csr_we      <= 1'b0;
      cur_silence  = silence;
      cur_thr      = thr;
   endtask

   function automatic int quiet_level();
      if (cur_thr == 0 || $urandom_range(0, 1) == 0)
         return -1 - int'($urandom_range(0, 32767));
      return int'($urandom_range(0, cur_thr - 1));
   endfunction

   // mostly silence-then-echo runs, with some full-range noise mixed in
   task automatic play_sequences(input int count, input int meas_cap);
      int done_items;
      int run;
      int span;
      done_items = 0;
      while (done_items < count && meas_seen < meas_cap) begin
         tx_burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) begin
            run = $urandom_range(1, 6);
            for (int k = 0; k < run; k++) send_sample(int'($urandom_range(0, 65535)));
         end else begin
            span = (cur_silence > 40) ? 40 : cur_silence;
            run  = $urandom_range(0, span + 6);
            for (int k = 0; k < run; k++) send_sample(quiet_level());
            send_sample(int'($urandom_range(cur_thr, 32767)));
            run++;
         end
         done_items += run;
      end
   endtask

   // receiver: random stalls per result, two long hold-offs to back up the input
   initial begin
      int wait_cycles;
      rsp_ch.ready <= 1'b0;
      results_taken = 0;
      meas_seen     = 0;
      rx_burst      = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (results_taken % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
         wait_cycles = rx_burst ? 0 : $urandom_range(0, 3);
         if (results_taken == 150 || results_taken == 320) wait_cycles = HOLD_CYCLES;
         repeat (wait_cycles) begin
            rsp_ch.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         meas_seen = rsp_ch.payload.measurements_taken;
         results_taken++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int opening [6];
      int echo_run [16];
      int phase_no;
      int len;
      opening  = '{-32768, 32767, 0, -1, 1, 3277};
      // threshold 100, silence 2: detection on the impulse's third word, then a restart just after
      // the impulse ends, then a longer listen
      echo_run = '{99, 50, 100, -5, 7, 99, 32767, 0, 0, 0, -32768, 99, -1, 32767, 100, 0};

      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      csr_we       <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      tx_burst      = 1'b0;
      items_sent    = 0;
      cur_silence   = SILENCE_RESET;
      cur_thr       = THRESH_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i]) send_sample(opening[i]);
      program_meter(2, 100, 127, 3);
      foreach (echo_run[i]) send_sample(echo_run[i]);

      phase_no = 0;
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS && meas_seen < MEAS_CAP) begin
         case (phase_no)
            0: begin
               program_meter(0, 0, 127, 1);
               len = 20;
            end
            1: begin
               program_meter(1048575, 32767, 64, 2);
               len = 20;
            end
            2: begin
               program_meter($urandom_range(4, 40), 32767, $urandom_range(64, 127), 0);
               len = 50;
            end
            default: begin
               program_meter($urandom_range(4, 40), $urandom_range(1, 32766),
                             $urandom_range(64, 127), 0);
               len = $urandom_range(40, 80);
            end
         endcase
         play_sequences(len, MEAS_CAP);
         phase_no++;
      end

      // a limit of zero acts as one: the next measurement ends measuring
      program_meter(3, 1000, 0, 0);
      play_sequences(40, 255);
      program_meter(3, 1000, 1, 0);
      play_sequences(20, 255);

      settle();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
